// ===== hw/rtl/ceq_pkg.sv =====
// Shared constants, codes and request structs of the coalescing event queue.
package ceq_pkg;

	localparam int MAX_TYPES  = 64;
	localparam int RING_DEPTH = 64;

	localparam int TYPE_W  = 6;
	localparam int FOLD_W  = 32;
	localparam int BLOB_W  = 64;
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int IDX_W   = RING_AW + 1;
	localparam int LG_W    = $clog2(RING_AW + 1);

	localparam int EC_W    = 7;
	localparam int MODE_W  = 2;
	localparam int RSL_W   = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W   = 7;

	localparam int ACT_W   = 2;
	localparam int STAT_W  = 3;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 112;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RING_LOG2   = 2'd2;

	// fold modes
	localparam logic [MODE_W-1:0] CEQ_OR  = 2'd0;
	localparam logic [MODE_W-1:0] CEQ_ADD = 2'd1;

	// actions
	localparam logic [ACT_W-1:0] ACT_POST    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CONSUME = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLR_OVF = 2'd2;

	// result status
	localparam logic [STAT_W-1:0] ST_QUEUED    = 3'd0;
	localparam logic [STAT_W-1:0] ST_COALESCED = 3'd1;
	localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
	localparam logic [STAT_W-1:0] ST_MODE      = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;
	localparam logic [STAT_W-1:0] ST_CONSUMED  = 3'd5;
	localparam logic [STAT_W-1:0] ST_IDLE      = 3'd6;

	typedef struct packed {
		logic [TYPE_W-1:0] rd_addr;
		logic              fold_we;
		logic              blob_we;
		logic [TYPE_W-1:0] wr_addr;
		logic [FOLD_W-1:0] fold_wd;
		logic [BLOB_W-1:0] blob_wd;
	} tmem_req_t;

	typedef struct packed {
		logic [RING_AW-1:0] rd_addr;
		logic               we;
		logic [RING_AW-1:0] wr_addr;
		logic [TYPE_W-1:0]  wd;
	} ring_req_t;

endpackage

// ===== hw/rtl/ceq_type_mem.sv =====
// Per-type coalesce word and blob memories, registered read.
module ceq_type_mem (
	input  logic                      clk,
	input  ceq_pkg::tmem_req_t        req,
	output logic [ceq_pkg::FOLD_W-1:0] fold_rd,
	output logic [ceq_pkg::BLOB_W-1:0] blob_rd
);

	logic [ceq_pkg::FOLD_W-1:0] fold_mem [ceq_pkg::MAX_TYPES];
	logic [ceq_pkg::BLOB_W-1:0] blob_mem [ceq_pkg::MAX_TYPES];

	always_ff @(posedge clk) begin
		if (req.fold_we) begin
			fold_mem[req.wr_addr] <= req.fold_wd;
		end
		if (req.blob_we) begin
			blob_mem[req.wr_addr] <= req.blob_wd;
		end
		fold_rd <= fold_mem[req.rd_addr];
		blob_rd <= blob_mem[req.rd_addr];
	end

endmodule

// ===== hw/rtl/ceq_ring_mem.sv =====
// Index ring memory holding queued event types, registered read.
module ceq_ring_mem (
	input  logic                      clk,
	input  ceq_pkg::ring_req_t        req,
	output logic [ceq_pkg::TYPE_W-1:0] rd_data
);

	logic [ceq_pkg::TYPE_W-1:0] ring_mem [ceq_pkg::RING_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			ring_mem[req.wr_addr] <= req.wd;
		end
		rd_data <= ring_mem[req.rd_addr];
	end

endmodule

// ===== hw/rtl/coalescing_event_queue_top.sv =====
// Coalescing event queue. Takes one item at a time. For a post, a clear-overflow,
// an unused action or a consume of an empty ring, the type memory is read at
// acceptance, then the word is folded and written back, then the result is
// registered. A consume of a non-empty ring reads the ring at acceptance, then
// the type memory at the ring entry, then the result is registered. The input
// reopens in the cycle after the result is registered, so no new item is taken
// before the last one is through. This order follows from the registered reads
// of the type and ring memories and the chained reads on consume. While the
// receiver holds a result, the next item is still accepted, but it only commits
// once that result is taken. Posted marks live in flip-flops and clear at reset;
// a type whose mark is clear reads its coalesce word as zero, so the word memory
// needs no clearing pass. Configuration writes are always taken (cfg_ready is
// high) and must only be issued while no item is in flight.
module coalescing_event_queue_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ceq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ceq_pkg::CFG_W-1:0]         cfg_data,
	// item input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: event_type[5:0], fold_value[37:6], blob_value[101:38], zero pad
	input  logic [ceq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// tuser: action[1:0]
	input  logic [ceq_pkg::ACT_W-1:0]         s_axis_tuser,
	// result output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: out_type[5:0], out_fold[37:6], out_blob[101:38], overflowed[102],
	//        highest_type[108:103], zero pad
	output logic [ceq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// tuser: status[2:0]
	output logic [ceq_pkg::STAT_W-1:0]        m_axis_tuser
);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
	localparam logic [1:0] S_EXEC = 2'd1;  // post / clear / no-op / empty consume
	localparam logic [1:0] S_RING = 2'd2;  // ring entry read back, read type mem
	localparam logic [1:0] S_CONS = 2'd3;  // type data read back, finish consume

	logic [1:0] state_q;

	// configuration
	logic [ceq_pkg::EC_W-1:0]   ec_q;
	logic [ceq_pkg::MODE_W-1:0] mode_q;
	logic [ceq_pkg::RSL_W-1:0]  rsl_q;

	// architectural state outside the memories
	logic [ceq_pkg::MAX_TYPES-1:0] mark_q;
	logic [ceq_pkg::IDX_W-1:0]     prod_q;
	logic [ceq_pkg::IDX_W-1:0]     cons_q;
	logic                          ovf_q;
	logic [ceq_pkg::TYPE_W-1:0]    high_q;

	// captured item
	logic [ceq_pkg::ACT_W-1:0]  act_q;
	logic [ceq_pkg::TYPE_W-1:0] type_q;
	logic [ceq_pkg::FOLD_W-1:0] val_q;
	logic [ceq_pkg::BLOB_W-1:0] blob_q;

	// output register
	logic                          m_valid_q;
	logic [ceq_pkg::STAT_W-1:0]    o_stat_q;
	logic [ceq_pkg::TYPE_W-1:0]    o_type_q;
	logic [ceq_pkg::FOLD_W-1:0]    o_fold_q;
	logic [ceq_pkg::BLOB_W-1:0]    o_blob_q;

	// memory interfaces
	ceq_pkg::tmem_req_t          tmem_req;
	ceq_pkg::ring_req_t          ring_req;
	logic [ceq_pkg::FOLD_W-1:0]  fold_rd;
	logic [ceq_pkg::BLOB_W-1:0]  blob_rd;
	logic [ceq_pkg::TYPE_W-1:0]  ring_rd;

	// input field views
	logic [ceq_pkg::TYPE_W-1:0] in_type;
	logic [ceq_pkg::FOLD_W-1:0] in_val;
	logic [ceq_pkg::BLOB_W-1:0] in_blob;

	logic in_acc;
	logic out_free;
	logic go;

	// ring geometry
	logic [ceq_pkg::LG_W-1:0]    ring_lg;
	logic [ceq_pkg::IDX_W-1:0]   entries;
	logic [ceq_pkg::RING_AW-1:0] ring_mask;
	logic [ceq_pkg::IDX_W-1:0]   used;
	logic                        ring_full;
	logic                        ring_empty;

	// post datapath
	logic                        is_post;
	logic                        range_bad;
	logic                        mode_ok;
	logic                        was_posted;
	logic [ceq_pkg::FOLD_W-1:0]  old_fold;
	logic [ceq_pkg::FOLD_W-1:0]  new_fold;
	logic [ceq_pkg::STAT_W-1:0]  exec_stat;
	logic                        do_queue;
	logic                        do_mark;
	logic                        do_ovf;

	assign in_type = s_axis_tdata[5:0];
	assign in_val  = s_axis_tdata[37:6];
	assign in_blob = s_axis_tdata[101:38];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign go            = out_free && ((state_q == S_EXEC) || (state_q == S_CONS));

	// ring size log2: zero acts as one, above the memory depth's log2 clips to it
	always_comb begin
		if (rsl_q == '0) begin
			ring_lg = ceq_pkg::LG_W'(1);
		end else if (rsl_q > ceq_pkg::RSL_W'(ceq_pkg::RING_AW)) begin
			ring_lg = ceq_pkg::LG_W'(ceq_pkg::RING_AW);
		end else begin
			ring_lg = ceq_pkg::LG_W'(rsl_q);
		end
	end

	assign entries    = ceq_pkg::IDX_W'(1) << ring_lg;
	assign ring_mask  = ceq_pkg::RING_AW'(entries - ceq_pkg::IDX_W'(1));
	assign used       = prod_q - cons_q;  // wraps modulo the index range
	assign ring_full  = (used >= entries);
	assign ring_empty = (prod_q == cons_q);

	// post evaluation in S_EXEC, memory data is for type_q
	assign is_post    = (act_q == ceq_pkg::ACT_POST);
	// counts above MAX_TYPES never reject a 6-bit type
	assign range_bad  = (ec_q <= ceq_pkg::EC_W'(ceq_pkg::MAX_TYPES)) &&
	                    ({1'b0, type_q} >= ec_q);
	assign mode_ok    = (mode_q == ceq_pkg::CEQ_OR) || (mode_q == ceq_pkg::CEQ_ADD);
	assign was_posted = mark_q[type_q];
	assign old_fold   = was_posted ? fold_rd : '0;
	assign new_fold   = (mode_q == ceq_pkg::CEQ_OR) ? (old_fold | val_q) : (old_fold + val_q);

	always_comb begin
		exec_stat = ceq_pkg::ST_IDLE;
		do_queue  = 1'b0;
		do_mark   = 1'b0;
		do_ovf    = 1'b0;
		if (is_post) begin
			if (range_bad) begin
				exec_stat = ceq_pkg::ST_RANGE;
			end else if (!mode_ok) begin
				exec_stat = ceq_pkg::ST_MODE;
			end else if (was_posted) begin
				exec_stat = ceq_pkg::ST_COALESCED;
			end else if (ring_full) begin
				exec_stat = ceq_pkg::ST_OVERFLOW;
				do_mark   = 1'b1;
				do_ovf    = 1'b1;
			end else begin
				exec_stat = ceq_pkg::ST_QUEUED;
				do_mark   = 1'b1;
				do_queue  = 1'b1;
			end
		end
	end

	// memory requests
	always_comb begin
		tmem_req = '0;
		case (state_q)
			S_IDLE: begin
				tmem_req.rd_addr = in_type;
			end
			S_EXEC: begin
				tmem_req.rd_addr = type_q;
			end
			default: begin
				tmem_req.rd_addr = ring_rd;
			end
		endcase
		tmem_req.wr_addr = type_q;
		tmem_req.fold_wd = new_fold;
		tmem_req.blob_wd = blob_q;
		tmem_req.blob_we = go && (state_q == S_EXEC) && is_post && !range_bad;
		tmem_req.fold_we = go && (state_q == S_EXEC) && is_post && !range_bad && mode_ok;
	end

	always_comb begin
		ring_req         = '0;
		ring_req.rd_addr = cons_q[ceq_pkg::RING_AW-1:0] & ring_mask;
		ring_req.wr_addr = prod_q[ceq_pkg::RING_AW-1:0] & ring_mask;
		ring_req.wd      = type_q;
		ring_req.we      = go && (state_q == S_EXEC) && do_queue;
	end

	ceq_type_mem u_type_mem (
		.clk     (clk),
		.req     (tmem_req),
		.fold_rd (fold_rd),
		.blob_rd (blob_rd)
	);

	ceq_ring_mem u_ring_mem (
		.clk     (clk),
		.req     (ring_req),
		.rd_data (ring_rd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q   <= ceq_pkg::EC_W'(64);
			mode_q <= ceq_pkg::CEQ_OR;
			rsl_q  <= ceq_pkg::RSL_W'(6);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ceq_pkg::REG_EVENT_COUNT: ec_q   <= cfg_data[ceq_pkg::EC_W-1:0];
				ceq_pkg::REG_FOLD_MODE:   mode_q <= cfg_data[ceq_pkg::MODE_W-1:0];
				ceq_pkg::REG_RING_LOG2:   rsl_q  <= cfg_data[ceq_pkg::RSL_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture, payload only
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= s_axis_tuser;
			type_q <= in_type;
			val_q  <= in_val;
			blob_q <= in_blob;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mark_q  <= '0;
			prod_q  <= '0;
			cons_q  <= '0;
			ovf_q   <= 1'b0;
			high_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if ((s_axis_tuser == ceq_pkg::ACT_CONSUME) && !ring_empty) begin
							state_q <= S_RING;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (go) begin
						state_q <= S_IDLE;
						if (is_post && !range_bad && (type_q > high_q)) begin
							high_q <= type_q;
						end
						if (do_mark) begin
							mark_q[type_q] <= 1'b1;
						end
						if (do_queue) begin
							prod_q <= prod_q + ceq_pkg::IDX_W'(1);
						end
						if (do_ovf) begin
							ovf_q <= 1'b1;
						end else if (act_q == ceq_pkg::ACT_CLR_OVF) begin
							ovf_q <= 1'b0;
						end
					end
				end
				S_RING: begin
					state_q <= S_CONS;
				end
				S_CONS: begin
					if (go) begin
						state_q         <= S_IDLE;
						mark_q[ring_rd] <= 1'b0;
						cons_q          <= cons_q + ceq_pkg::IDX_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (state_q == S_CONS) begin
				o_stat_q <= ceq_pkg::ST_CONSUMED;
				o_type_q <= ring_rd;
				o_fold_q <= mark_q[ring_rd] ? fold_rd : '0;
				o_blob_q <= blob_rd;
			end else begin
				o_stat_q <= exec_stat;
				o_type_q <= '0;
				o_fold_q <= '0;
				o_blob_q <= '0;
			end
		end
	end

	// flag and highest type are already updated when the result is shown
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = o_stat_q;
	assign m_axis_tdata  = {3'b000, high_q, ovf_q, o_blob_q, o_fold_q, o_type_q};

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after taking an item");

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= ceq_pkg::IDX_W'(ceq_pkg::RING_DEPTH))
		else $error("ring occupancy beyond its depth");

	a_queue_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (state_q == S_EXEC) && do_queue)
		|=> (prod_q == $past(prod_q) + ceq_pkg::IDX_W'(1)) && m_valid_q)
		else $error("queued post did not advance producer index");

	a_consume_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (state_q == S_CONS)) |=> !mark_q[$past(ring_rd)] && (state_q == S_IDLE))
		else $error("consumed type still marked posted");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the coalescing event queue: predictor, driver, monitor, watchdog.
module testbench;
	import ceq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// action code the block treats as a no-op
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	// fold modes with no meaning; posts under them stop after storing the blob
	localparam logic [MODE_W-1:0] MODE_BAD_LO = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BAD_HI = 2'd3;

	localparam int STALL_HOLD  = 300;   // long receiver hold-off, in cycles
	localparam int IDLE_LIMIT  = 3000;  // cycles with no handshake before giving up

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [TYPE_W-1:0] etype;
		logic [FOLD_W-1:0] fval;
		logic [BLOB_W-1:0] blob;
	} ev_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [TYPE_W-1:0] otype;
		logic [FOLD_W-1:0] ofold;
		logic [BLOB_W-1:0] oblob;
		logic              ovf;
		logic [TYPE_W-1:0] top_type;
	} ev_result_t;

	// DUT ports; every input starts at a known value
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [ACT_W-1:0]       s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic [STAT_W-1:0]      m_axis_tuser;

	coalescing_event_queue_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// ---------------------------------------------------------------
	// Predictor state: a shadow copy of the queue and its registers
	// ---------------------------------------------------------------
	logic [EC_W-1:0]   ec_cfg;
	logic [MODE_W-1:0] mode_cfg;
	logic [RSL_W-1:0]  lg_cfg;

	logic [FOLD_W-1:0] fold_word [MAX_TYPES];
	logic [BLOB_W-1:0] blob_word [MAX_TYPES];
	logic              posted    [MAX_TYPES];
	logic [TYPE_W-1:0] ring      [RING_DEPTH];
	logic [IDX_W-1:0]  prod_pos;    // producer/consumer count modulo twice the depth
	logic [IDX_W-1:0]  cons_idx;
	logic              ovf_flag;
	logic [TYPE_W-1:0] top_seen;

	ev_item_t   pending_items [$];  // filled by the sequencer, drained by the driver
	ev_result_t due_results   [$];  // expected results in order of acceptance
	ev_item_t   on_offer;
	logic       offering;

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int stall_req = 0;
	int stall_taken = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	task automatic reset_queue_model();
		ec_cfg   = 7'd64;
		mode_cfg = CEQ_OR;
		lg_cfg   = 3'd6;
		for (int i = 0; i < MAX_TYPES; i++) begin
			fold_word[i] = '0;
			blob_word[i] = '0;
			posted[i]    = 1'b0;
		end
		for (int i = 0; i < RING_DEPTH; i++)
			ring[i] = '0;
		prod_pos = '0;
		cons_idx = '0;
		ovf_flag = 1'b0;
		top_seen = '0;
	endtask

	// types in use; counts above the table size act as the table size
	function automatic int unsigned type_cap();
		return (ec_cfg > MAX_TYPES) ? MAX_TYPES : ec_cfg;
	endfunction

	// ring entries in use; log2 of zero acts as one, large sizes clip to the depth
	function automatic int unsigned ring_slots();
		int unsigned lg;
		int unsigned n;
		lg = (lg_cfg == 0) ? 1 : lg_cfg;
		n = 1 << lg;
		return (n > RING_DEPTH) ? RING_DEPTH : n;
	endfunction

	function automatic logic [STAT_W-1:0] post_event(ev_item_t it);
		logic [TYPE_W-1:0] t;
		logic [IDX_W-1:0]  used;
		int unsigned       n;
		t = it.etype;
		if (t >= type_cap())
			return ST_RANGE;
		if (t > top_seen)
			top_seen = t;
		blob_word[t] = it.blob;
		if (mode_cfg == CEQ_OR)
			fold_word[t] = fold_word[t] | it.fval;
		else if (mode_cfg == CEQ_ADD)
			fold_word[t] = fold_word[t] + it.fval;
		else
			return ST_MODE;
		if (posted[t])
			return ST_COALESCED;
		// mark stays set even when the ring has no room
		posted[t] = 1'b1;
		n = ring_slots();
		used = prod_pos - cons_idx;
		if (used >= n) begin
			ovf_flag = 1'b1;
			return ST_OVERFLOW;
		end
		ring[RING_AW'(prod_pos & (n - 1))] = t;
		prod_pos = prod_pos + 1'b1;
		return ST_QUEUED;
	endfunction

	// advances the shadow queue by one accepted item and returns its result
	function automatic ev_result_t next_queue_result(ev_item_t it);
		ev_result_t        r;
		logic [TYPE_W-1:0] t;
		r = '0;
		r.status = ST_IDLE;
		case (it.action)
			ACT_POST: begin
				r.status = post_event(it);
			end
			ACT_CONSUME: begin
				if (prod_pos != cons_idx) begin
					t = ring[RING_AW'(cons_idx & (ring_slots() - 1))];
					cons_idx = cons_idx + 1'b1;
					r.otype = t;
					r.ofold = fold_word[t];
					r.oblob = blob_word[t];
					posted[t] = 1'b0;
					fold_word[t] = '0;
					r.status = ST_CONSUMED;
				end
			end
			ACT_CLR_OVF: begin
				ovf_flag = 1'b0;
			end
			default: ;
		endcase
		r.ovf = ovf_flag;
		r.top_type = top_seen;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Clock and watchdog
	// ---------------------------------------------------------------
	initial begin
		forever #4 clk = ~clk;
	end

	// counts cycles in which no item, result or register write moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("coalescing_event_queue_top verification failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Driver: offers pending items, predicts each one as it is taken
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			offering = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				due_results.push_back(next_queue_result(on_offer));
				offering = 1'b0;
			end
			// valid is held until the handshake, and assigned once per edge
			if (!offering) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_offer = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= IN_DATA_W'({on_offer.blob, on_offer.fval, on_offer.etype});
					s_axis_tuser <= on_offer.action;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random back-pressure, long hold-off, result checking
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ev_result_t got;
		ev_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status   = m_axis_tuser;
				got.otype    = m_axis_tdata[5:0];
				got.ofold    = m_axis_tdata[37:6];
				got.oblob    = m_axis_tdata[101:38];
				got.ovf      = m_axis_tdata[102];
				got.top_type = m_axis_tdata[108:103];
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result: expected none, actual %h", $time,
						got);
				end else begin
					want = due_results.pop_front();
					check_field("status", 64'(want.status), 64'(got.status));
					check_field("out_type", 64'(want.otype), 64'(got.otype));
					check_field("out_fold", 64'(want.ofold), 64'(got.ofold));
					check_field("out_blob", want.oblob, got.oblob);
					check_field("overflowed", 64'(want.ovf), 64'(got.ovf));
					check_field("highest_type", 64'(want.top_type), 64'(got.top_type));
				end
			end
			// a hold-off request from the sequencer starts a long stall here
			if (stall_req != stall_taken) begin
				stall_taken = stall_req;
				hold_left = STALL_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencer helpers
	// ---------------------------------------------------------------
	task automatic push_item(input logic [ACT_W-1:0] act, input logic [TYPE_W-1:0] t,
		input logic [FOLD_W-1:0] v, input logic [BLOB_W-1:0] b);
		ev_item_t it;
		it.action = act;
		it.etype = t;
		it.fval = v;
		it.blob = b;
		pending_items.push_back(it);
	endtask

	// everything sent, taken and answered, plus trailing slack before returning
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || due_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_EVENT_COUNT: ec_cfg = val;
			REG_FOLD_MODE:   mode_cfg = val[MODE_W-1:0];
			REG_RING_LOG2:   lg_cfg = val[RSL_W-1:0];
			default: ;
		endcase
	endtask

	// empty the ring so that a ring-size change never exposes stale slots
	task automatic drain_ring();
		logic [IDX_W-1:0] queued;
		queued = prod_pos - cons_idx;
		repeat (queued)
			push_item(ACT_CONSUME, TYPE_W'($urandom), $urandom, {$urandom, $urandom});
		wait_idle();
	endtask

	function automatic logic [FOLD_W-1:0] rand_fold();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// bursts of posts to live types followed by consumes, with some noise mixed in
	task automatic queue_random(input int n);
		int          left;
		int          k;
		int unsigned lim;
		logic [TYPE_W-1:0] t;
		left = n;
		lim = type_cap();
		while (left > 0) begin
			k = $urandom_range(6, 1);
			repeat (k) begin
				if (lim == 0)
					t = TYPE_W'($urandom);
				else if ($urandom_range(99) < 30)
					t = TYPE_W'($urandom_range((lim < 4 ? lim : 4) - 1, 0));
				else
					t = TYPE_W'($urandom_range(lim - 1, 0));
				push_item(ACT_POST, t, rand_fold(), {$urandom, $urandom});
			end
			left -= k;
			k = $urandom_range(k + 1, 1);
			repeat (k)
				push_item(ACT_CONSUME, TYPE_W'($urandom), $urandom, {$urandom, $urandom});
			left -= k;
			if ($urandom_range(99) < 15) begin
				case ($urandom_range(3))
					0: begin
						t = (lim < MAX_TYPES) ? TYPE_W'($urandom_range(MAX_TYPES - 1, lim))
							: TYPE_W'($urandom);
						push_item(ACT_POST, t, rand_fold(), {$urandom, $urandom});
					end
					1: push_item(ACT_CLR_OVF, TYPE_W'($urandom), $urandom, {$urandom, $urandom});
					2: push_item(ACT_UNUSED, TYPE_W'($urandom), $urandom, {$urandom, $urandom});
					default: push_item(ACT_CONSUME, TYPE_W'($urandom), $urandom,
						{$urandom, $urandom});
				endcase
				left--;
			end
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] ec, input logic [CFG_W-1:0] mode,
		input logic [CFG_W-1:0] lg, input int idle_s, input int idle_r, input int n,
		input bit hold, input bit pause);
		drain_ring();
		write_reg(REG_EVENT_COUNT, ec);
		write_reg(REG_FOLD_MODE, mode);
		write_reg(REG_RING_LOG2, lg);
		@(negedge clk);
		send_idle_pct = idle_s;
		recv_stall_pct = idle_r;
		if (pause) begin
			// sender stops halfway until every result is back
			queue_random(n / 2);
			wait_idle();
			queue_random(n - n / 2);
		end else begin
			queue_random(n);
		end
		// receiver blocks while the sender keeps offering, so the input backs up
		if (hold)
			stall_req++;
		wait_idle();
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		reset_queue_model();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: queue two types, coalesce one, consume past empty
		push_item(ACT_POST, 6'd0, 32'h0, 64'h0);
		push_item(ACT_POST, 6'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		push_item(ACT_POST, 6'd5, 32'h0000_1234, 64'h0123_4567_89AB_CDEF);
		push_item(ACT_CONSUME, 6'd0, 32'h0, 64'h0);
		push_item(ACT_CONSUME, 6'd0, 32'h0, 64'h0);
		push_item(ACT_CONSUME, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		push_item(ACT_CLR_OVF, 6'd0, 32'h0, 64'h0);
		push_item(ACT_UNUSED, 6'd0, 32'h0, 64'h0);
		wait_idle();

		// ten types, wrapping add, type at and far above the count
		write_reg(REG_EVENT_COUNT, 7'd10);
		write_reg(REG_FOLD_MODE, CFG_W'(CEQ_ADD));
		push_item(ACT_POST, 6'd9, 32'hFFFF_FFFF, 64'hAAAA_5555_AAAA_5555);
		push_item(ACT_POST, 6'd9, 32'h0000_0002, 64'h5555_AAAA_5555_AAAA);
		push_item(ACT_POST, 6'd10, 32'h1, 64'h1);
		push_item(ACT_POST, 6'd63, 32'h1, 64'h1);
		push_item(ACT_CONSUME, 6'd0, 32'h0, 64'h0);
		wait_idle();

		// invalid fold modes: blob stored, post stops
		write_reg(REG_FOLD_MODE, CFG_W'(MODE_BAD_LO));
		push_item(ACT_POST, 6'd4, 32'h0F0F_0F0F, 64'hDEAD_BEEF_0000_0001);
		wait_idle();
		write_reg(REG_FOLD_MODE, CFG_W'(MODE_BAD_HI));
		push_item(ACT_POST, 6'd6, 32'hF0F0_F0F0, 64'hDEAD_BEEF_0000_0002);
		wait_idle();

		// zero types in use: every post dropped
		write_reg(REG_FOLD_MODE, CFG_W'(CEQ_OR));
		write_reg(REG_EVENT_COUNT, 7'd0);
		push_item(ACT_POST, 6'd0, 32'h1, 64'h1);
		wait_idle();

		// two-entry ring: overflow, repost of the overflowed type, clear, drain
		write_reg(REG_EVENT_COUNT, 7'd64);
		write_reg(REG_RING_LOG2, 7'd1);
		push_item(ACT_POST, 6'd1, 32'h8000_0001, 64'h1111_1111_1111_1111);
		push_item(ACT_POST, 6'd63, 32'h7FFF_FFFE, 64'h2222_2222_2222_2222);
		push_item(ACT_POST, 6'd2, 32'h0000_00FF, 64'h3333_3333_3333_3333);
		push_item(ACT_POST, 6'd2, 32'h0000_FF00, 64'h4444_4444_4444_4444);
		push_item(ACT_CLR_OVF, 6'd0, 32'h0, 64'h0);
		push_item(ACT_CONSUME, 6'd0, 32'h0, 64'h0);
		push_item(ACT_CONSUME, 6'd0, 32'h0, 64'h0);
		push_item(ACT_CONSUME, 6'd0, 32'h0, 64'h0);
		wait_idle();

		// random phases:      count   mode                   log2  send rcv  items hold pause
		run_phase(7'd64,  CFG_W'(CEQ_OR),      7'd6, 0,   0,  300,  1'b1, 1'b0);
		run_phase(7'd127, CFG_W'(CEQ_ADD),     7'd5, 50,  0,  300,  1'b0, 1'b0);
		run_phase(7'd33,  CFG_W'(CEQ_ADD),     7'd4, 0,   50, 300,  1'b0, 1'b1);
		run_phase(7'd64,  CFG_W'(CEQ_OR),      7'd7, 12,  12, 300,  1'b0, 1'b0);
		run_phase(7'd1,   CFG_W'(MODE_BAD_HI), 7'd0, 12,  12, 100,  1'b0, 1'b0);
		run_phase(7'd20,  CFG_W'(CEQ_OR),      7'd2, 50,  50, 300,  1'b1, 1'b0);
		run_phase(7'd64,  CFG_W'(MODE_BAD_LO), 7'd3, 0,   0,  100,  1'b0, 1'b0);
		run_phase(7'd64,  CFG_W'(CEQ_ADD),     7'd1, 12,  12, 200,  1'b0, 1'b0);

		// let any stray result show up before the verdict
		repeat (12) @(negedge clk);
		if (errors == 0)
			$display("coalescing_event_queue_top verification clean");
		else
			$display("coalescing_event_queue_top verification failed");
		$finish;
	end

endmodule
